// File: hdl/ipv6_style_address_formatter_assert.svh
// Assertion macros shared by the formatter modules.
`ifndef IPV6_STYLE_ADDRESS_FORMATTER_ASSERT_SVH
`define IPV6_STYLE_ADDRESS_FORMATTER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define FMT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define FMT_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/v6fmt_pkg.sv
`timescale 1ns / 1ps
package v6fmt_pkg;

  localparam int GROUP_COUNT = 8;
  localparam int GROUP_W = 16;
  localparam int GROUP_IDX_W = 3;
  localparam int LEAD_W = 2;
  localparam int CHAR_W = 8;
  localparam int SLOT_W = 3;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 8;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [SLOT_W-1:0] SLOT_LAST_DIGIT = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_COLON = 3'd4;
  localparam logic [GROUP_IDX_W-1:0] GROUP_FIRST = 3'd0;
  localparam logic [GROUP_IDX_W-1:0] GROUP_LAST = 3'd7;
  localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3a;
  localparam logic [CHAR_W-1:0] PAD_NONE = 8'h00;

  localparam logic [CFG_INDEX_W-1:0] REG_COMPRESS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_PAD = 1'b1;

  typedef enum logic [1:0] {
    KIND_NORMAL = 2'b00,
    KIND_COMP   = 2'b01,
    KIND_SKIP   = 2'b10
  } kind_t;

  typedef struct packed {
    logic [GROUP_W-1:0] group0;
    logic [GROUP_W-1:0] group1;
    logic [GROUP_W-1:0] group2;
    logic [GROUP_W-1:0] group3;
    logic [GROUP_W-1:0] group4;
    logic [GROUP_W-1:0] group5;
    logic [GROUP_W-1:0] group6;
    logic [GROUP_W-1:0] group7;
  } addr_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } text_word_t;

  typedef struct packed {
    logic [GROUP_COUNT-1:0][GROUP_W-1:0] groups;
    logic [GROUP_COUNT-1:0][1:0]         kinds;
    logic [GROUP_COUNT-1:0][LEAD_W-1:0]  leads;
    logic [CHAR_W-1:0]                   pad;
  } entry_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] c;
    case (nib)
      4'h0: c = 8'h30;
      4'h1: c = 8'h31;
      4'h2: c = 8'h32;
      4'h3: c = 8'h33;
      4'h4: c = 8'h34;
      4'h5: c = 8'h35;
      4'h6: c = 8'h36;
      4'h7: c = 8'h37;
      4'h8: c = 8'h38;
      4'h9: c = 8'h39;
      4'ha: c = 8'h61;
      4'hb: c = 8'h62;
      4'hc: c = 8'h63;
      4'hd: c = 8'h64;
      4'he: c = 8'h65;
      4'hf: c = 8'h66;
      default: c = 8'h30;
    endcase
    return c;
  endfunction

endpackage

// File: hdl/v6fmt_front.sv
`timescale 1ns / 1ps
module v6fmt_front
  import v6fmt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   addr_valid,
  input  addr_word_t             addr,
  output logic                   addr_stall,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   full,
  output logic                   push,
  output entry_t                 entry
);

  logic                    compress;
  logic [CHAR_W-1:0]       pad;
  logic [GROUP_W-1:0]      grp [GROUP_COUNT];
  logic [GROUP_COUNT-1:0]  zero;
  logic                    active;
  logic                    done;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      compress <= 1'b0;
      pad <= PAD_NONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COMPRESS: compress <= cfg_data[0];
        REG_PAD: pad <= cfg_data;
        default: ;
      endcase
    end
  end

  assign grp[0] = addr.group0;
  assign grp[1] = addr.group1;
  assign grp[2] = addr.group2;
  assign grp[3] = addr.group3;
  assign grp[4] = addr.group4;
  assign grp[5] = addr.group5;
  assign grp[6] = addr.group6;
  assign grp[7] = addr.group7;

  assign addr_stall = full;
  assign push = addr_valid && !full;

  always_comb begin
    active = 1'b0;
    done = 1'b0;
    entry.pad = pad;
    for (int i = 0; i < GROUP_COUNT; i++) begin
      zero[i] = (grp[i] == '0);
      entry.groups[i] = grp[i];
      if (grp[i][15:12] != 4'h0) begin
        entry.leads[i] = 2'd0;
      end else if (grp[i][11:8] != 4'h0) begin
        entry.leads[i] = 2'd1;
      end else if (grp[i][7:4] != 4'h0) begin
        entry.leads[i] = 2'd2;
      end else begin
        entry.leads[i] = 2'd3;
      end
      entry.kinds[i] = KIND_NORMAL;
      if (compress && zero[i] && !done) begin
        entry.kinds[i] = active ? KIND_SKIP : KIND_COMP;
        active = 1'b1;
      end else if (active) begin
        done = 1'b1;
        active = 1'b0;
      end
    end
  end

endmodule

// File: hdl/v6fmt_queue.sv
`timescale 1ns / 1ps
module v6fmt_queue
  import v6fmt_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wr_entry,
  output logic   full,
  input  logic   pop,
  output logic   empty,
  output entry_t head
);

  `include "ipv6_style_address_formatter_assert.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `FMT_ASSERT(a_no_push_full, !(push && full), "word pushed into full queue")
  `FMT_ASSERT(a_no_pop_empty, !(pop && empty), "word popped from empty queue")
  `FMT_ASSERT(a_count_bound, count <= CNT_W'(DEPTH), "queue count overflow")

endmodule

// File: hdl/v6fmt_back.sv
`timescale 1ns / 1ps
module v6fmt_back
  import v6fmt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       empty,
  input  entry_t     head,
  output logic       pop,
  output logic       text_valid,
  input  logic       text_stall,
  output text_word_t text
);

  `include "ipv6_style_address_formatter_assert.svh"

  logic [GROUP_IDX_W-1:0] cur_g;
  logic [GROUP_IDX_W-1:0] cur_g_next;
  logic [SLOT_W-1:0]      cur_slot;
  logic [SLOT_W-1:0]      cur_slot_next;
  logic                   fresh;
  logic                   fresh_next;
  kind_t                  kind;
  logic [LEAD_W-1:0]      lead;
  logic [GROUP_W-1:0]     grp;
  logic [SLOT_W-1:0]      start_slot;
  logic [SLOT_W-1:0]      end_slot;
  logic [SLOT_W-1:0]      slot;
  logic [3:0]             nib;
  logic [CHAR_W-1:0]      code;
  logic [GROUP_IDX_W-1:0] nxt_g;
  logic                   has_next;
  logic                   last_char;
  logic                   produce;

  always_comb begin
    kind = kind_t'(head.kinds[cur_g]);
    lead = head.leads[cur_g];
    grp = head.groups[cur_g];

    case (kind)
      KIND_NORMAL: start_slot = (head.pad != PAD_NONE) ? '0 : {1'b0, lead};
      KIND_COMP: start_slot = (cur_g == GROUP_FIRST) ? SLOT_LAST_DIGIT : SLOT_COLON;
      default: start_slot = SLOT_COLON;
    endcase
    end_slot = (kind == KIND_NORMAL && cur_g == GROUP_LAST) ? SLOT_LAST_DIGIT : SLOT_COLON;
    slot = fresh ? start_slot : cur_slot;

    case (slot[1:0])
      2'd0: nib = grp[15:12];
      2'd1: nib = grp[11:8];
      2'd2: nib = grp[7:4];
      2'd3: nib = grp[3:0];
      default: nib = grp[3:0];
    endcase

    if (slot == SLOT_COLON || kind == KIND_COMP) begin
      code = CHAR_COLON;
    end else if (slot < {1'b0, lead}) begin
      code = head.pad;
    end else begin
      code = hex_char(nib);
    end

    has_next = 1'b0;
    nxt_g = GROUP_FIRST;
    for (int j = GROUP_COUNT - 1; j >= 0; j--) begin
      if (GROUP_IDX_W'(j) > cur_g && kind_t'(head.kinds[j]) != KIND_SKIP) begin
        has_next = 1'b1;
        nxt_g = GROUP_IDX_W'(j);
      end
    end
    last_char = (slot == end_slot) && !has_next;
  end

  assign produce = !empty && (!text_valid || !text_stall);
  assign pop = produce && last_char;

  always_comb begin
    cur_g_next = cur_g;
    cur_slot_next = cur_slot;
    fresh_next = fresh;
    if (produce) begin
      if (slot == end_slot) begin
        cur_g_next = last_char ? GROUP_FIRST : nxt_g;
        fresh_next = 1'b1;
      end else begin
        cur_slot_next = slot + 1'b1;
        fresh_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_g <= GROUP_FIRST;
      cur_slot <= '0;
      fresh <= 1'b1;
      text_valid <= 1'b0;
    end else begin
      cur_g <= cur_g_next;
      cur_slot <= cur_slot_next;
      fresh <= fresh_next;
      if (produce) begin
        text_valid <= 1'b1;
      end else if (!text_stall) begin
        text_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      text.char_code <= code;
      text.last <= last_char;
    end
  end

  `FMT_ASSERT(a_slot_bound, !fresh |-> cur_slot <= SLOT_COLON, "character slot out of range")

endmodule

// File: hdl/ipv6_style_address_formatter.sv
`timescale 1ns / 1ps
// Channel  Handshake               Word
// addr     addr_valid/addr_stall   addr_word_t: group0..group7, 16 bits each
// text     text_valid/text_stall   text_word_t: char_code, last
// cfg      cfg_valid/cfg_ready     cfg_index (0 compress_zeros, 1 pad_char), cfg_data
//
// One character leaves per cycle while text_stall is low, from the
// single-character output register of the back end. The first character
// of an address is registered there once its word has passed through the queue.
// Reset clears compress_zeros and pad_char to 0, empties the queue, drops output.
// text_stall holds the output register; addr_stall rises while the
// QUEUE_DEPTH-entry queue between front and back is full.
module ipv6_style_address_formatter
  import v6fmt_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   addr_valid,
  output logic                   addr_stall,
  input  addr_word_t             addr,
  output logic                   text_valid,
  input  logic                   text_stall,
  output text_word_t             text,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic   full;
  logic   push;
  logic   empty;
  logic   pop;
  entry_t wr_entry;
  entry_t head;

  v6fmt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .addr_valid (addr_valid),
    .addr       (addr),
    .addr_stall (addr_stall),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .full       (full),
    .push       (push),
    .entry      (wr_entry)
  );

  v6fmt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  v6fmt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (empty),
    .head       (head),
    .pop        (pop),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text       (text)
  );

endmodule
